/* rtl/dda_pkg.sv */
// shared types and constants for the line pixel stepper
`timescale 1ns / 1ps
`default_nettype none

package dda_pkg;

  localparam int COORD_W = 10;
  localparam int COLOR_W = 32;
  localparam int ADDR_W  = 20;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // one classified request between the front and the back
  typedef struct packed {
    logic               op;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] mag_x;
    logic [COORD_W-1:0] mag_y;
    logic               neg_x;
    logic               neg_y;
    logic [COORD_W-1:0] len;
    logic [COLOR_W-1:0] color;
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_EMIT
  } back_state_t;

endpackage : dda_pkg

`default_nettype wire

/* rtl/dda_line_pixel_stepper_unit.sv */
// top level of the line pixel stepper
`timescale 1ns / 1ps
`default_nettype none

// DDA line rasterizer with queue-style ports on both sides. A load request
// (in_op = 0) sets up a line from its two endpoints and color; each step
// request (in_op = 1) yields one pixel address (row * SCREEN_WIDTH + column,
// rounded half up, low 20 bits) with the color and a flag on the final
// pixel. The end point is not drawn, a zero-length line and a step with no
// active line give no result. Requests enter a two-entry queue and are
// carried out in order. A load of nonzero length runs the bit-serial divider
// that forms both axis increments together, one quotient bit per cycle.
module dda_line_pixel_stepper_unit #(
  parameter int SCREEN_WIDTH = 1024,
  parameter int FRAC_BITS    = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_push,
  output logic                             in_full,
  input  wire logic                        in_op,
  input  wire logic [dda_pkg::COORD_W-1:0] in_start_x,
  input  wire logic [dda_pkg::COORD_W-1:0] in_start_y,
  input  wire logic [dda_pkg::COORD_W-1:0] in_end_x,
  input  wire logic [dda_pkg::COORD_W-1:0] in_end_y,
  input  wire logic [dda_pkg::COLOR_W-1:0] in_line_color,
  output logic                             out_empty,
  input  wire logic                        out_pop,
  output logic [dda_pkg::ADDR_W-1:0]       out_pixel_address,
  output logic [dda_pkg::COLOR_W-1:0]      out_pixel_color,
  output logic                             out_last_pixel
);

  dda_pkg::cmd_t front_cmd;
  dda_pkg::cmd_t q_data;
  logic          q_empty;
  logic          q_pop;

  dda_front u_front (
    .in_op         (in_op),
    .in_start_x    (in_start_x),
    .in_start_y    (in_start_y),
    .in_end_x      (in_end_x),
    .in_end_y      (in_end_y),
    .in_line_color (in_line_color),
    .cmd           (front_cmd)
  );

  dda_cmd_q u_cmd_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .push_data (front_cmd),
    .full      (in_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  dda_back #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .FRAC_BITS    (FRAC_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_data            (q_data),
    .q_pop             (q_pop),
    .out_pop           (out_pop),
    .out_empty         (out_empty),
    .out_pixel_address (out_pixel_address),
    .out_pixel_color   (out_pixel_color),
    .out_last_pixel    (out_last_pixel)
  );

endmodule : dda_line_pixel_stepper_unit

`default_nettype wire

/* rtl/dda_front.sv */
// front end: classifies each request and works out deltas and line length
`timescale 1ns / 1ps
`default_nettype none

module dda_front (
  input  wire logic                        in_op,
  input  wire logic [dda_pkg::COORD_W-1:0] in_start_x,
  input  wire logic [dda_pkg::COORD_W-1:0] in_start_y,
  input  wire logic [dda_pkg::COORD_W-1:0] in_end_x,
  input  wire logic [dda_pkg::COORD_W-1:0] in_end_y,
  input  wire logic [dda_pkg::COLOR_W-1:0] in_line_color,
  output dda_pkg::cmd_t                    cmd
);

  logic                        neg_x;
  logic                        neg_y;
  logic [dda_pkg::COORD_W-1:0] mag_x;
  logic [dda_pkg::COORD_W-1:0] mag_y;

  always_comb begin
    neg_x = in_end_x < in_start_x;
    neg_y = in_end_y < in_start_y;
    mag_x = neg_x ? (in_start_x - in_end_x) : (in_end_x - in_start_x);
    mag_y = neg_y ? (in_start_y - in_end_y) : (in_end_y - in_start_y);

    cmd.op      = in_op;
    cmd.start_x = in_start_x;
    cmd.start_y = in_start_y;
    cmd.mag_x   = mag_x;
    cmd.mag_y   = mag_y;
    cmd.neg_x   = neg_x;
    cmd.neg_y   = neg_y;
    // longer axis span is the pixel count
    cmd.len     = (mag_x >= mag_y) ? mag_x : mag_y;
    cmd.color   = in_line_color;
  end

endmodule : dda_front

`default_nettype wire

/* rtl/dda_cmd_q.sv */
// two-entry request queue between the front and the back
`timescale 1ns / 1ps
`default_nettype none

module dda_cmd_q (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  dda_pkg::cmd_t push_data,
  output logic          full,
  input  wire logic     pop,
  output dda_pkg::cmd_t pop_data,
  output logic          empty
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);

  dda_pkg::cmd_t      entry_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_nxt;
  logic [PTR_W:0]     count_r;
  logic [PTR_W:0]     count_nxt;
  logic               do_push;
  logic               do_pop;

  always_comb begin
    full     = count_r == (PTR_W+1)'(DEPTH);
    empty    = count_r == '0;
    pop_data = entry_r[rd_ptr_r];
    do_push  = push && !full;
    do_pop   = pop && !empty;

    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule : dda_cmd_q

`default_nettype wire

/* rtl/dda_back.sv */
// back end: increment divider, position stepper and result register
`timescale 1ns / 1ps
`default_nettype none

module dda_back #(
  parameter int SCREEN_WIDTH = 1024,
  parameter int FRAC_BITS    = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        q_empty,
  input  dda_pkg::cmd_t                    q_data,
  output logic                             q_pop,
  input  wire logic                        out_pop,
  output logic                             out_empty,
  output logic [dda_pkg::ADDR_W-1:0]       out_pixel_address,
  output logic [dda_pkg::COLOR_W-1:0]      out_pixel_color,
  output logic                             out_last_pixel
);

  localparam int CW     = dda_pkg::COORD_W;
  localparam int POS_W  = CW + FRAC_BITS + 1;
  localparam int QUO_W  = FRAC_BITS + 1;
  localparam int STEP_W = FRAC_BITS + 2;
  localparam int REM_W  = CW + 1;
  localparam int RND_W  = CW + 1;
  localparam int ITER_W = $clog2(FRAC_BITS + 1);

  dda_pkg::back_state_t st_r;
  dda_pkg::back_state_t st_nxt;

  logic [POS_W-1:0]              pos_x_r;
  logic [POS_W-1:0]              pos_y_r;
  logic [STEP_W-1:0]             step_x_r;
  logic [STEP_W-1:0]             step_y_r;
  logic [CW-1:0]                 left_r;
  logic [dda_pkg::COLOR_W-1:0]   color_r;
  logic [RND_W-1:0]              rnd_x_r;
  logic [RND_W-1:0]              rnd_y_r;

  // divider state, both axes share one length and one counter
  logic [CW-1:0]                 len_r;
  logic [REM_W-1:0]              rem_x_r;
  logic [REM_W-1:0]              rem_y_r;
  logic [QUO_W-1:0]              quo_x_r;
  logic [QUO_W-1:0]              quo_y_r;
  logic                          neg_x_r;
  logic                          neg_y_r;
  logic [ITER_W-1:0]             iter_r;

  logic [REM_W-1:0]              sh_x;
  logic [REM_W-1:0]              sh_y;
  logic                          ge_x;
  logic                          ge_y;
  logic [REM_W-1:0]              rem_x_nxt;
  logic [REM_W-1:0]              rem_y_nxt;
  logic [QUO_W-1:0]              quo_x_nxt;
  logic [QUO_W-1:0]              quo_y_nxt;
  logic [STEP_W-1:0]             step_x_nxt;
  logic [STEP_W-1:0]             step_y_nxt;

  logic                          out_valid_r;
  logic [dda_pkg::ADDR_W-1:0]    out_addr_r;
  logic [dda_pkg::COLOR_W-1:0]   out_color_r;
  logic                          out_last_r;
  logic                          out_wr;
  logic                          is_load;
  logic                          last_iter;

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      dda_pkg::S_IDLE: begin
        if (!q_empty) begin
          if (q_data.op == dda_pkg::OP_LOAD) begin
            st_nxt = (q_data.len != '0) ? dda_pkg::S_DIV : dda_pkg::S_IDLE;
          end else begin
            st_nxt = (left_r != '0) ? dda_pkg::S_EMIT : dda_pkg::S_IDLE;
          end
        end
      end
      dda_pkg::S_DIV: begin
        if (last_iter) begin
          st_nxt = dda_pkg::S_IDLE;
        end
      end
      dda_pkg::S_EMIT: begin
        if (out_wr) begin
          st_nxt = dda_pkg::S_IDLE;
        end
      end
      default: st_nxt = dda_pkg::S_IDLE;
    endcase
  end

  // state decodes
  always_comb begin
    q_pop     = (st_r == dda_pkg::S_IDLE) && !q_empty;
    is_load   = q_data.op == dda_pkg::OP_LOAD;
    last_iter = (st_r == dda_pkg::S_DIV) && (iter_r == ITER_W'(1));
    out_wr    = (st_r == dda_pkg::S_EMIT) && (!out_valid_r || out_pop);
  end

  // one restoring division step per cycle on each axis
  always_comb begin
    sh_x = {rem_x_r[REM_W-2:0], 1'b0};
    sh_y = {rem_y_r[REM_W-2:0], 1'b0};
    ge_x = sh_x >= REM_W'(len_r);
    ge_y = sh_y >= REM_W'(len_r);
    rem_x_nxt = ge_x ? sh_x - REM_W'(len_r) : sh_x;
    rem_y_nxt = ge_y ? sh_y - REM_W'(len_r) : sh_y;
    quo_x_nxt = {quo_x_r[QUO_W-2:0], ge_x};
    quo_y_nxt = {quo_y_r[QUO_W-2:0], ge_y};
    step_x_nxt = neg_x_r ? -{1'b0, quo_x_nxt} : {1'b0, quo_x_nxt};
    step_y_nxt = neg_y_r ? -{1'b0, quo_y_nxt} : {1'b0, quo_y_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= dda_pkg::S_IDLE;
      pos_x_r  <= '0;
      pos_y_r  <= '0;
      step_x_r <= '0;
      step_y_r <= '0;
      left_r   <= '0;
      color_r  <= '0;
      iter_r   <= '0;
    end else begin
      st_r <= st_nxt;
      if (q_pop && is_load) begin
        pos_x_r  <= POS_W'({q_data.start_x, {FRAC_BITS{1'b0}}});
        pos_y_r  <= POS_W'({q_data.start_y, {FRAC_BITS{1'b0}}});
        left_r   <= q_data.len;
        color_r  <= q_data.color;
        step_x_r <= '0;
        step_y_r <= '0;
        iter_r   <= ITER_W'(FRAC_BITS);
      end
      if (st_r == dda_pkg::S_DIV) begin
        iter_r <= iter_r - 1'b1;
        if (last_iter) begin
          step_x_r <= step_x_nxt;
          step_y_r <= step_y_nxt;
        end
      end
      if (out_wr) begin
        pos_x_r <= pos_x_r + {{(POS_W-STEP_W){step_x_r[STEP_W-1]}}, step_x_r};
        pos_y_r <= pos_y_r + {{(POS_W-STEP_W){step_y_r[STEP_W-1]}}, step_y_r};
        left_r  <= left_r - 1'b1;
      end
    end
  end

  // divider datapath; integer bit is set only when the span equals the length
  always_ff @(posedge clk) begin
    if (q_pop && is_load) begin
      len_r   <= q_data.len;
      neg_x_r <= q_data.neg_x;
      neg_y_r <= q_data.neg_y;
      quo_x_r <= QUO_W'(q_data.mag_x == q_data.len);
      quo_y_r <= QUO_W'(q_data.mag_y == q_data.len);
      rem_x_r <= (q_data.mag_x == q_data.len) ? '0 : REM_W'(q_data.mag_x);
      rem_y_r <= (q_data.mag_y == q_data.len) ? '0 : REM_W'(q_data.mag_y);
    end else if (st_r == dda_pkg::S_DIV) begin
      rem_x_r <= rem_x_nxt;
      rem_y_r <= rem_y_nxt;
      quo_x_r <= quo_x_nxt;
      quo_y_r <= quo_y_nxt;
    end
  end

  // rounded pixel coordinates are a registered copy of the rounded position
  always_ff @(posedge clk) begin
    rnd_x_r <= RND_W'((pos_x_r + POS_W'(1 << (FRAC_BITS - 1))) >> FRAC_BITS);
    rnd_y_r <= RND_W'((pos_y_r + POS_W'(1 << (FRAC_BITS - 1))) >> FRAC_BITS);
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_wr) begin
      out_valid_r <= 1'b1;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_wr) begin
      out_addr_r  <= dda_pkg::ADDR_W'(dda_pkg::ADDR_W'(rnd_y_r) *
                                      dda_pkg::ADDR_W'(SCREEN_WIDTH)) +
                     dda_pkg::ADDR_W'(rnd_x_r);
      out_color_r <= color_r;
      out_last_r  <= left_r == CW'(1);
    end
  end

  assign out_empty         = !out_valid_r;
  assign out_pixel_address = out_addr_r;
  assign out_pixel_color   = out_color_r;
  assign out_last_pixel    = out_last_r;

  a_div_has_pixels: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == dda_pkg::S_DIV) |-> (left_r != '0))
    else $error("divide running on an empty line");

  a_emit_has_pixels: assert property (@(posedge clk) disable iff (!rst_n)
    out_wr |-> (left_r != '0))
    else $error("pixel emitted with none left");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_wr && (left_r == CW'(1))) |=> (out_last_r && left_r == '0))
    else $error("final pixel not flagged");

  a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (st_r == dda_pkg::S_IDLE && !q_empty))
    else $error("request taken while busy");

endmodule : dda_back

`default_nettype wire
